// ===== hdl/vsd_pkg.sv =====
// Shared types and constants of the video stream deframer.
`default_nettype none

package vsd_pkg;

   // Length of the device name that opens the channel, in words.
   localparam logic [6:0] NAME_BYTES   = 7'd64;
   // Length of the stream header and of each frame header, in words.
   localparam logic [6:0] HEADER_BYTES = 7'd12;

   // Depth of the queue between the parser and the result register.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      STAGE_NAME    = 2'd0,
      STAGE_STREAM  = 2'd1,
      STAGE_FRAME   = 2'd2,
      STAGE_PAYLOAD = 2'd3
   } vsd_stage_type;

   typedef enum logic [1:0] {
      KIND_RESOLUTION = 2'd0,
      KIND_PAYLOAD    = 2'd1,
      KIND_EMPTY      = 2'd2
   } vsd_kind_type;

   typedef struct packed {
      vsd_kind_type kind;
      logic [31:0]  width;
      logic [31:0]  height;
      logic [61:0]  timestamp;
      logic         is_config;
      logic         prepend_config;
      logic [7:0]   data_byte;
      logic         packet_first;
      logic         packet_last;
   } vsd_rsp_type;

endpackage : vsd_pkg

`default_nettype wire

// ===== hdl/video_stream_deframer.sv =====
// Top level of the video stream deframer.
`default_nettype none

// Takes the video channel one word (byte) per cycle, skips the device name,
// reports the stream resolution once, then splits each frame into its
// payload words, tagged with timestamp, config and first/last flags; a zero
// size packet gives one empty-packet word. A media packet that follows a
// non-empty config packet carries prepend_config, and the consumer joins the
// two. Sustained rate is one input word per cycle while req_full is low. When
// the queue is empty and the result register is free or being popped, an
// accepted word's result is on the rsp_ ports once the parser's record has
// been written into a four-entry queue and then loaded into the result
// register. req_full rises only when that queue is full, so the input keeps
// flowing while a result waits for rsp_pop.
module video_stream_deframer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_stream_byte,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [1:0]       rsp_kind,
   output logic [31:0]      rsp_width,
   output logic [31:0]      rsp_height,
   output logic [61:0]      rsp_timestamp,
   output logic             rsp_is_config,
   output logic             rsp_prepend_config,
   output logic [7:0]       rsp_data_byte,
   output logic             rsp_packet_first,
   output logic             rsp_packet_last
);
   import vsd_pkg::*;

   logic        accept;
   logic        rec_push;
   vsd_rsp_type rec;
   logic        q_full;
   logic        q_valid;
   logic        q_pop;
   vsd_rsp_type q_rec;
   vsd_rsp_type out_rec;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   vsd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .stream_byte (req_stream_byte),
      .rec_push    (rec_push),
      .rec         (rec)
   );

   vsd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (rec_push),
      .push_rec (rec),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .head_rec (q_rec)
   );

   vsd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_rec   (q_rec),
      .q_pop   (q_pop),
      .pop     (rsp_pop),
      .empty   (rsp_empty),
      .out_rec (out_rec)
   );

   assign rsp_kind           = out_rec.kind;
   assign rsp_width          = out_rec.width;
   assign rsp_height         = out_rec.height;
   assign rsp_timestamp      = out_rec.timestamp;
   assign rsp_is_config      = out_rec.is_config;
   assign rsp_prepend_config = out_rec.prepend_config;
   assign rsp_data_byte      = out_rec.data_byte;
   assign rsp_packet_first   = out_rec.packet_first;
   assign rsp_packet_last    = out_rec.packet_last;

endmodule : video_stream_deframer

`default_nettype wire

// ===== hdl/vsd_front.sv =====
// Parser that takes channel words and turns them into result records.
`default_nettype none

module vsd_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic [7:0]          stream_byte,
   output logic                     rec_push,
   output vsd_pkg::vsd_rsp_type     rec
);
   import vsd_pkg::*;

   vsd_stage_type stage_ff, stage_in;
   logic [6:0]    count_ff, count_in;
   logic [63:0]   high_ff, high_in;
   logic [31:0]   low_ff, low_in;
   logic [31:0]   left_ff, left_in;
   logic          pend_ff, pend_in;
   logic          cfg_ff, cfg_in;

   logic [6:0]    cnt_inc;
   logic [63:0]   shift_high;
   logic [31:0]   shift_low;
   logic          name_done;
   logic          hdr_done;
   logic          size_zero;
   logic          pay_last;
   logic          cfg_new;
   logic          pend_new;

   assign cnt_inc    = count_ff + 7'd1;
   assign shift_high = {high_ff[55:0], low_ff[31:24]};
   assign shift_low  = {low_ff[23:0], stream_byte};
   assign name_done  = (cnt_inc >= NAME_BYTES);
   assign hdr_done   = (cnt_inc >= HEADER_BYTES);
   assign size_zero  = (shift_low == 32'd0);
   assign pay_last   = (left_ff <= 32'd1);
   assign cfg_new    = shift_high[63];
   assign pend_new   = cfg_new ? !size_zero : pend_ff;

   // Next parse stage.
   always_comb begin
      stage_in = stage_ff;
      if (accept) begin
         unique case (stage_ff)
            STAGE_NAME: begin
               if (name_done) stage_in = STAGE_STREAM;
            end
            STAGE_STREAM: begin
               if (hdr_done) stage_in = STAGE_FRAME;
            end
            STAGE_FRAME: begin
               if (hdr_done && !size_zero) stage_in = STAGE_PAYLOAD;
            end
            STAGE_PAYLOAD: begin
               if (pay_last) stage_in = STAGE_FRAME;
            end
            default: stage_in = STAGE_NAME;
         endcase
      end
   end

   // Header shifting, packet bookkeeping and the record for each result.
   always_comb begin
      count_in = count_ff;
      high_in  = high_ff;
      low_in   = low_ff;
      left_in  = left_ff;
      pend_in  = pend_ff;
      cfg_in   = cfg_ff;
      rec_push = 1'b0;
      rec      = '0;
      if (accept) begin
         unique case (stage_ff)
            STAGE_NAME: begin
               count_in = name_done ? 7'd0 : cnt_inc;
            end
            STAGE_STREAM, STAGE_FRAME: begin
               high_in  = shift_high;
               low_in   = shift_low;
               count_in = hdr_done ? 7'd0 : cnt_inc;
               if (hdr_done) begin
                  if (stage_ff == STAGE_STREAM) begin
                     rec_push   = 1'b1;
                     rec.kind   = KIND_RESOLUTION;
                     rec.width  = shift_high[31:0];
                     rec.height = shift_low;
                  end else begin
                     cfg_in = cfg_new;
                     if (size_zero) begin
                        rec_push           = 1'b1;
                        rec.kind           = KIND_EMPTY;
                        rec.timestamp      = shift_high[61:0];
                        rec.is_config      = cfg_new;
                        rec.prepend_config = pend_new && !cfg_new;
                        rec.packet_first   = 1'b1;
                        rec.packet_last    = 1'b1;
                        pend_in            = cfg_new ? pend_new : 1'b0;
                     end else begin
                        pend_in = pend_new;
                        left_in = shift_low;
                     end
                  end
               end
            end
            STAGE_PAYLOAD: begin
               rec_push           = 1'b1;
               rec.kind           = KIND_PAYLOAD;
               rec.timestamp      = high_ff[61:0];
               rec.is_config      = cfg_ff;
               rec.prepend_config = pend_ff && !cfg_ff;
               rec.data_byte      = stream_byte;
               rec.packet_first   = (left_ff == low_ff);
               rec.packet_last    = pay_last;
               left_in            = left_ff - 32'd1;
               if (pay_last) begin
                  left_in  = 32'd0;
                  count_in = 7'd0;
                  if (!cfg_ff) pend_in = 1'b0;
               end
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= STAGE_NAME;
         count_ff <= 7'd0;
         high_ff  <= 64'd0;
         low_ff   <= 32'd0;
         left_ff  <= 32'd0;
         pend_ff  <= 1'b0;
         cfg_ff   <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         count_ff <= count_in;
         high_ff  <= high_in;
         low_ff   <= low_in;
         left_ff  <= left_in;
         pend_ff  <= pend_in;
         cfg_ff   <= cfg_in;
      end
   end

endmodule : vsd_front

`default_nettype wire

// ===== hdl/vsd_queue.sv =====
// Short queue of result records between the parser and the result register.
`default_nettype none

module vsd_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire vsd_pkg::vsd_rsp_type  push_rec,
   output logic                       full,
   input  wire logic                  pop,
   output logic                       valid,
   output vsd_pkg::vsd_rsp_type       head_rec
);
   import vsd_pkg::*;

   vsd_rsp_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]      count_ff, count_in;
   logic                     do_push;
   logic                     do_pop;

   assign full     = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign head_rec = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule : vsd_queue

`default_nettype wire

// ===== hdl/vsd_back.sv =====
// Result register that presents the oldest record to the consumer.
`default_nettype none

module vsd_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_valid,
   input  wire vsd_pkg::vsd_rsp_type  q_rec,
   output logic                       q_pop,
   input  wire logic                  pop,
   output logic                       empty,
   output vsd_pkg::vsd_rsp_type       out_rec
);
   import vsd_pkg::*;

   logic        valid_ff, valid_in;
   vsd_rsp_type rec_ff;

   // The register loads a queued record whenever it is free or being popped.
   assign q_pop    = q_valid && (!valid_ff || pop);
   assign valid_in = q_pop ? 1'b1 : (valid_ff && !pop);
   assign empty    = !valid_ff;
   assign out_rec  = rec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rec_ff <= q_rec;
      end
   end

endmodule : vsd_back

`default_nettype wire
